FILE: rtl/core/iis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iis_pkg
// Shared types, widths and helpers of the integral image stream unit.
// ----------------------------------------------------------------------------
package iis_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;

    localparam int CFG_W       = 12;
    localparam int PIX_W       = 8;
    localparam int SUM_W       = 32;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int WDIM_W      = $clog2(MAX_WIDTH + 1);
    localparam int HDIM_W      = $clog2(MAX_HEIGHT + 1);
    localparam int ROWSUM_W    = $clog2(MAX_WIDTH * 255 + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    typedef enum logic
    {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    // One classified pixel request handed from the front end to the back end.
    typedef struct packed
    {
        logic [COL_W-1:0]    col;
        logic                use_above;
        logic                frame_last;
        logic [ROWSUM_W-1:0] row_sum;
    } iis_item_t;

    function automatic logic [WDIM_W-1:0] eff_width(input logic [CFG_W-1:0] value);
        logic [WDIM_W-1:0] result;
        if (value == '0)
            result = WDIM_W'(1);
        else if (32'(value) > 32'(MAX_WIDTH))
            result = WDIM_W'(MAX_WIDTH);
        else
            result = WDIM_W'(value);
        return result;
    endfunction

    function automatic logic [HDIM_W-1:0] eff_height(input logic [CFG_W-1:0] value);
        logic [HDIM_W-1:0] result;
        if (value == '0)
            result = HDIM_W'(1);
        else if (32'(value) > 32'(MAX_HEIGHT))
            result = HDIM_W'(MAX_HEIGHT);
        else
            result = HDIM_W'(value);
        return result;
    endfunction

endpackage

FILE: rtl/core/iis_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iis_front
// Accepts pixels, tracks column, row and row running sum, and classifies each
// request with its column, not-first-row flag and end-of-frame flag.
// ----------------------------------------------------------------------------
module iis_front
    import iis_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [PIX_W-1:0]  pixel_value,
    input  logic [WDIM_W-1:0] width,
    input  logic [HDIM_W-1:0] height,
    output iis_item_t         item
);

    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic [ROWSUM_W-1:0] rowsum_reg;
    logic [ROWSUM_W-1:0] rowsum_next;

    logic [COL_W-1:0]    col;
    logic [ROWSUM_W-1:0] sum;
    logic                row_end;
    logic                frame_end;

    always_comb
    begin
        // A column beyond a narrowed width counts as the last column.
        if (WDIM_W'(col_reg) >= width)
            col = COL_W'(width - WDIM_W'(1));
        else
            col = col_reg;

        sum       = rowsum_reg + ROWSUM_W'(pixel_value);
        row_end   = (WDIM_W'(col) + WDIM_W'(1)) >= width;
        frame_end = row_end && ((HDIM_W'(row_reg) + HDIM_W'(1)) >= height);

        item.col        = col;
        item.use_above  = (row_reg != '0);
        item.frame_last = frame_end;
        item.row_sum    = sum;

        col_next    = col_reg;
        row_next    = row_reg;
        rowsum_next = rowsum_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next    = '0;
                rowsum_next = '0;
                row_next    = frame_end ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next    = col + COL_W'(1);
                rowsum_next = sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            rowsum_reg <= '0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            rowsum_reg <= rowsum_next;
        end
    end

`ifndef SYNTH
    a_frame_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.frame_last |=> (col_reg == '0) && (row_reg == '0))
        else $error("counters did not wrap after the last pixel of a frame");
`endif

endmodule

FILE: rtl/core/iis_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iis_queue
// Short register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module iis_queue
    import iis_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  iis_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      pop_valid,
    output iis_item_t pop_item
);

    iis_item_t         store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = store_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("request pushed into a full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("request popped from an empty queue");
`endif

endmodule

FILE: rtl/core/iis_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iis_back
// Reads the line store, adds the row running sum, writes the result back and
// holds it in the output register until it is taken.
// ----------------------------------------------------------------------------
module iis_back
    import iis_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  iis_item_t        q_item,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [SUM_W-1:0] area_sum,
    output logic             frame_last
);

    logic [SUM_W-1:0] line_mem [MAX_WIDTH];
    logic [SUM_W-1:0] rd_data_reg;

    iis_item_t        s2_item_reg;
    logic             s2_valid_reg;
    logic             hazard_reg;
    logic [SUM_W-1:0] byp_data_reg;

    logic             out_valid_reg;
    logic [SUM_W-1:0] out_sum_reg;
    logic             out_last_reg;

    logic             s2_fire;
    logic [SUM_W-1:0] above;
    logic [SUM_W-1:0] sum;

    assign s2_fire = s2_valid_reg && (!out_valid_reg || !out_stall);
    assign pop     = q_valid && (!s2_valid_reg || s2_fire);

    always_comb
    begin
        // The write that lands on the same edge as this request's read is
        // not yet in the read data, so it is taken from the bypass register.
        if (!s2_item_reg.use_above)
            above = '0;
        else if (hazard_reg)
            above = byp_data_reg;
        else
            above = rd_data_reg;
        sum = SUM_W'(s2_item_reg.row_sum) + above;
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire)
            line_mem[s2_item_reg.col] <= sum;
        if (pop)
            rd_data_reg <= line_mem[q_item.col];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s2_item_reg  <= q_item;
            byp_data_reg <= sum;
        end
        if (s2_fire)
        begin
            out_sum_reg  <= sum;
            out_last_reg <= s2_item_reg.frame_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            hazard_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                s2_valid_reg <= 1'b1;
                hazard_reg   <= s2_fire && (s2_item_reg.col == q_item.col);
            end
            else if (s2_fire)
            begin
                s2_valid_reg <= 1'b0;
                hazard_reg   <= 1'b0;
            end

            if (s2_fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign area_sum   = out_sum_reg;
    assign frame_last = out_last_reg;

`ifndef SYNTH
    a_bypass_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
        hazard_reg |-> s2_valid_reg)
        else $error("bypass flagged with no request in the add stage");
`endif

endmodule

FILE: rtl/core/integral_image_stream_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integral_image_stream_unit
// Requests pass from the queue through the add stage to the output register.
// Throughput: one pixel per cycle while out_stall is low. The line store has
// one read and one write port; a same-column read-after-write is bypassed in
// the add stage. Reset clears the counters, the queue and the output register
// and sets the frame size to 640 x 480; the line store is not cleared.
// ----------------------------------------------------------------------------
module integral_image_stream_unit
    import iis_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [PIX_W-1:0]  pixel_value,

    output logic              out_valid,
    input  logic              out_stall,
    output logic [SUM_W-1:0]  area_sum,
    output logic              frame_last
);

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    reg_index_t       reg_sel;
    logic             cfg_write;

    logic             accept;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    iis_item_t        front_item;
    iis_item_t        q_item;

    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (reg_sel)
            REG_FRAME_WIDTH:  prdata = DATA_W'(width_reg);
            REG_FRAME_HEIGHT: prdata = DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_FRAME_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    iis_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pixel_value (pixel_value),
        .width       (eff_width(width_reg)),
        .height      (eff_height(height_reg)),
        .item        (front_item)
    );

    iis_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_item)
    );

    iis_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .area_sum   (area_sum),
        .frame_last (frame_last)
    );

endmodule
